// File: sv/aes_pkg.sv
// ----------------------------------------------------------------------------
// aes_pkg
// Shared constants, S-box tables and round helpers for the AES-256 CBC block.
// ----------------------------------------------------------------------------
`default_nettype none
package aes_pkg;

	localparam int NUM_ROUNDS = 14;
	localparam int RK_DEPTH = 30;

	localparam logic [3:0] REG_KEY0 = 4'd0;
	localparam logic [3:0] REG_KEY1 = 4'd1;
	localparam logic [3:0] REG_KEY2 = 4'd2;
	localparam logic [3:0] REG_KEY3 = 4'd3;
	localparam logic [3:0] REG_IV_HIGH = 4'd4;
	localparam logic [3:0] REG_IV_LOW = 4'd5;
	localparam logic [3:0] REG_MODE = 4'd6;

	localparam logic [7:0] RC_INIT = 8'h01;

	typedef logic [7:0] byte_t;

	function automatic byte_t sbox(input byte_t x);
		byte_t t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return t[x];
	endfunction

	function automatic byte_t inv_sbox(input byte_t x);
		byte_t t [256];
		t = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
		return t[x];
	endfunction

	function automatic byte_t xt(input byte_t x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic byte_t gb(input logic [127:0] s, input int i);
		return s[127 - 8*i -: 8];
	endfunction

	// forward: SubBytes + ShiftRows
	function automatic logic [127:0] sub_shift(input logic [127:0] s);
		logic [127:0] o;
		o = '0;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				o[127 - 8*(c*4+r) -: 8] = sbox(gb(s, ((c + r) & 3)*4 + r));
		return o;
	endfunction

	function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
		logic [127:0] o;
		o = '0;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				o[127 - 8*(((c + r) & 3)*4 + r) -: 8] = inv_sbox(gb(s, c*4 + r));
		return o;
	endfunction

	function automatic logic [127:0] mix(input logic [127:0] s);
		logic [127:0] o;
		byte_t a0, a1, a2, a3;
		o = '0;
		for (int c = 0; c < 4; c++) begin
			a0 = gb(s, 4*c); a1 = gb(s, 4*c+1); a2 = gb(s, 4*c+2); a3 = gb(s, 4*c+3);
			o[127 - 8*(4*c) -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
			o[127 - 8*(4*c+1) -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
			o[127 - 8*(4*c+2) -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
			o[127 - 8*(4*c+3) -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
		end
		return o;
	endfunction

	function automatic logic [127:0] inv_mix(input logic [127:0] s);
		logic [127:0] o;
		byte_t a [4];
		byte_t d2 [4];
		byte_t d4 [4];
		byte_t d8 [4];
		o = '0;
		for (int c = 0; c < 4; c++) begin
			for (int k = 0; k < 4; k++) begin
				a[k] = gb(s, 4*c + k);
				d2[k] = xt(a[k]);
				d4[k] = xt(d2[k]);
				d8[k] = xt(d4[k]);
			end
			for (int r = 0; r < 4; r++)
				o[127 - 8*(4*c+r) -: 8] =
					(d8[r] ^ d4[r] ^ d2[r]) ^
					(d8[(r+1)&3] ^ d2[(r+1)&3] ^ a[(r+1)&3]) ^
					(d8[(r+2)&3] ^ d4[(r+2)&3] ^ a[(r+2)&3]) ^
					(d8[(r+3)&3] ^ a[(r+3)&3]);
		end
		return o;
	endfunction

endpackage
`default_nettype wire

// File: sv/aes_key_expand.sv
// ----------------------------------------------------------------------------
// aes_key_expand
// AES-256 key schedule: produces one 64-bit round key word per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module aes_key_expand (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [255:0] key,
	output logic             wr_en,
	output logic [4:0]       wr_addr,
	output logic [63:0]      wr_data,
	output logic             busy
);

	logic [255:0] win_q;
	logic [4:0]   idx_q;
	logic [7:0]   rc_q;
	logic         busy_q;
	logic [31:0]  w0, w1, t0, w1n, w0n, rot;

	// word pair 2i, 2i+1; window holds the last eight 32-bit words
	always_comb begin
		rot = {win_q[23:0], win_q[31:24]};
		if (idx_q[1:0] == 2'd0) begin
			t0 = {aes_pkg::sbox(rot[31:24]) ^ rc_q, aes_pkg::sbox(rot[23:16]),
				aes_pkg::sbox(rot[15:8]), aes_pkg::sbox(rot[7:0])};
		end else if (idx_q[1:0] == 2'd2) begin
			t0 = {aes_pkg::sbox(win_q[31:24]), aes_pkg::sbox(win_q[23:16]),
				aes_pkg::sbox(win_q[15:8]), aes_pkg::sbox(win_q[7:0])};
		end else begin
			t0 = win_q[31:0];
		end
		w0 = win_q[255:224] ^ t0;
		w1 = win_q[223:192] ^ w0;
		w0n = w0;
		w1n = w1;
	end

	assign busy = busy_q;
	assign wr_en = busy_q;
	assign wr_addr = idx_q;
	assign wr_data = (idx_q < 5'd4) ? win_q[255:192] : {w0n, w1n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
			rc_q <= aes_pkg::RC_INIT;
		end else if (start) begin
			busy_q <= 1'b1;
			idx_q <= '0;
			rc_q <= aes_pkg::RC_INIT;
		end else if (busy_q) begin
			idx_q <= idx_q + 5'd1;
			if (idx_q == 5'(aes_pkg::RK_DEPTH - 1))
				busy_q <= 1'b0;
			if (idx_q >= 5'd4 && idx_q[1:0] == 2'd0)
				rc_q <= aes_pkg::xt(rc_q);
		end
	end

	always_ff @(posedge clk) begin
		if (start)
			win_q <= key;
		else if (busy_q) begin
			if (idx_q < 5'd4)
				win_q <= {win_q[191:0], win_q[255:192]};
			else
				win_q <= {win_q[191:0], w0n, w1n};
		end
	end

endmodule
`default_nettype wire

// File: sv/aes256_cbc_cipher.sv
// ----------------------------------------------------------------------------
// aes256_cbc_cipher
// AES-256 CBC encrypt/decrypt of one 16-byte block per request.
// The round loop reads the two key words of each round one after the other
// from the round key memory, then registers the result for output; a new
// block is accepted only after the previous result has been registered.
// A key write holds off input while the round keys expand.
// Reset is asynchronous and clears registers; the chain restarts from the IV.
// ----------------------------------------------------------------------------
`default_nettype none
module aes256_cbc_cipher (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [5:0]   paddr,
	input  wire logic [63:0]  pwdata,
	output logic [63:0]       prdata,
	output logic              pready,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [127:0] s_tdata,  // block_low, block_high
	input  wire logic         s_tlast,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [127:0]      m_tdata,  // out_low, out_high
	output logic              m_tlast
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN = 2'd1;
	localparam logic [1:0] ST_OUT = 2'd2;

	logic [63:0] key_q [4];
	logic [127:0] iv_q, chain_q, st_q, in_q;
	logic [63:0] ka_q;
	logic mode_q, restart_q, last_q;
	logic [1:0] state_q;
	logic [4:0] cnt_q;
	logic [63:0] rk_mem [aes_pkg::RK_DEPTH];
	logic [63:0] rk_rd_q;
	logic [4:0] rd_addr;
	logic ke_wr, ke_busy;
	logic [4:0] ke_addr;
	logic [63:0] ke_data;
	logic wr_req;
	logic [3:0] reg_idx;
	logic [127:0] rk, chn;
	logic [127:0] out_q;
	logic out_v_q;
	logic out_last_q;
	logic [127:0] s_blk;
	logic out_go, cfg_restart, key_wr;
	// key expansion starts in the cycle after the write so it sees the new word
	logic kstart_q;

	assign pready = 1'b1;
	assign wr_req = psel && penable && pwrite;
	assign reg_idx = paddr[5:3] == 3'd7 ? 4'd15 : {1'b0, paddr[5:3]};
	assign key_wr = wr_req && reg_idx <= aes_pkg::REG_KEY3;
	assign cfg_restart = wr_req && reg_idx <= aes_pkg::REG_IV_LOW;

	always_comb begin
		case (reg_idx)
			aes_pkg::REG_KEY0: prdata = key_q[0];
			aes_pkg::REG_KEY1: prdata = key_q[1];
			aes_pkg::REG_KEY2: prdata = key_q[2];
			aes_pkg::REG_KEY3: prdata = key_q[3];
			aes_pkg::REG_IV_HIGH: prdata = iv_q[127:64];
			aes_pkg::REG_IV_LOW: prdata = iv_q[63:0];
			aes_pkg::REG_MODE: prdata = {63'd0, mode_q};
			default: prdata = '0;
		endcase
	end

	aes_key_expand u_kexp (
		.clk(clk),
		.arst_n(arst_n),
		.start(kstart_q),
		.key({key_q[0], key_q[1], key_q[2], key_q[3]}),
		.wr_en(ke_wr),
		.wr_addr(ke_addr),
		.wr_data(ke_data),
		.busy(ke_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q[0] <= '0; key_q[1] <= '0; key_q[2] <= '0; key_q[3] <= '0;
			iv_q <= '0;
			mode_q <= 1'b0;
			kstart_q <= 1'b0;
		end else begin
			kstart_q <= key_wr;
			if (wr_req) begin
				case (reg_idx)
					aes_pkg::REG_KEY0: key_q[0] <= pwdata;
					aes_pkg::REG_KEY1: key_q[1] <= pwdata;
					aes_pkg::REG_KEY2: key_q[2] <= pwdata;
					aes_pkg::REG_KEY3: key_q[3] <= pwdata;
					aes_pkg::REG_IV_HIGH: iv_q[127:64] <= pwdata;
					aes_pkg::REG_IV_LOW: iv_q[63:0] <= pwdata;
					aes_pkg::REG_MODE: mode_q <= pwdata[0];
					default: ;
				endcase
			end
		end
	end

	// round counter r in 0..14, key words 2r and 2r+1 (2(14-r), 2(14-r)+1 to decrypt) read one after the other
	assign rk = {ka_q, rk_rd_q};

	always_comb begin
		if (!mode_q) begin
			rd_addr = cnt_q;
		end else begin
			rd_addr = 5'(aes_pkg::RK_DEPTH - 2) - {cnt_q[4:1], 1'b0} + {4'd0, cnt_q[0]};
		end
	end

	always_ff @(posedge clk) begin
		if (ke_wr)
			rk_mem[ke_addr] <= ke_data;
		rk_rd_q <= rk_mem[rd_addr];
	end

	assign chn = restart_q ? iv_q : chain_q;

	logic [4:0] rd_cnt_q;
	logic       phase_q;

	assign s_blk = {s_tdata[63:0], s_tdata[127:64]};
	assign out_go = state_q == ST_OUT && (!out_v_q || m_tready);
	assign s_tready = state_q == ST_IDLE && !ke_busy && !kstart_q;
	assign m_tvalid = out_v_q;
	assign m_tdata = {out_q[63:0], out_q[127:64]};
	assign m_tlast = out_last_q;

	// cnt_q walks read addresses; phase_q marks cycles where read data is valid,
	// and a round is applied when the arriving word is odd
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			restart_q <= 1'b1;
			out_v_q <= 1'b0;
			phase_q <= 1'b0;
			rd_cnt_q <= '0;
		end else begin
			if (cfg_restart)
				restart_q <= 1'b1;
			else if (out_go)
				restart_q <= last_q;
			if (out_go)
				out_v_q <= 1'b1;
			else if (m_tready)
				out_v_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid && s_tready) begin
						state_q <= ST_RUN;
						cnt_q <= '0;
						phase_q <= 1'b0;
						rd_cnt_q <= '0;
					end
				end
				ST_RUN: begin
					phase_q <= 1'b1;
					if (phase_q)
						rd_cnt_q <= rd_cnt_q + 5'd1;
					if (cnt_q != 5'(aes_pkg::RK_DEPTH - 1))
						cnt_q <= cnt_q + 5'd1;
					if (phase_q && rd_cnt_q == 5'(aes_pkg::RK_DEPTH - 1))
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_go)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	logic [3:0] arnd;
	logic [127:0] anxt;
	assign arnd = rd_cnt_q[4:1];

	always_comb begin
		anxt = st_q;
		if (!mode_q) begin
			if (arnd == 4'd0)
				anxt = st_q ^ rk;
			else if (arnd == 4'(aes_pkg::NUM_ROUNDS))
				anxt = aes_pkg::sub_shift(st_q) ^ rk;
			else
				anxt = aes_pkg::mix(aes_pkg::sub_shift(st_q)) ^ rk;
		end else begin
			if (arnd == 4'd0)
				anxt = st_q ^ rk;
			else if (arnd == 4'(aes_pkg::NUM_ROUNDS))
				anxt = aes_pkg::inv_sub_shift(st_q) ^ rk;
			else
				anxt = aes_pkg::inv_mix(aes_pkg::inv_sub_shift(st_q) ^ rk);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid && s_tready) begin
			in_q <= s_blk;
			last_q <= s_tlast;
			chain_q <= chn;
			st_q <= mode_q ? s_blk : (s_blk ^ chn);
		end else if (state_q == ST_RUN && phase_q) begin
			if (!rd_cnt_q[0])
				ka_q <= rk_rd_q;
			else
				st_q <= anxt;
		end else if (out_go) begin
			out_last_q <= last_q;
			if (mode_q) begin
				out_q <= st_q ^ chain_q;
				chain_q <= in_q;
			end else begin
				out_q <= st_q;
				chain_q <= st_q;
			end
		end
	end

endmodule
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stream test of the AES-256 CBC cipher: APB key/IV/direction setup, blocks
// pushed through the slave stream, results checked against an in-bench CBC
// model across encrypt and decrypt phases with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;

	localparam logic [3:0] REG_SPARE = 4'd7;
	localparam int STUCK_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		logic [127:0] blk;
		logic         last;
	} cbc_block_t;

	class cbc_scoreboard;
		logic [63:0]  regs [7];
		logic [7:0]   rkey [240];
		logic [7:0]   st [16];
		logic [7:0]   fwd [256];
		logic [7:0]   rev [256];
		logic [127:0] chain;
		logic         restart;
		cbc_block_t   expected_blocks [$];

		function new();
			logic [7:0] iv8, a;
			for (int x = 0; x < 256; x++) begin
				iv8 = 0;
				for (int y = 1; y < 256; y++)
					if (x != 0 && gf_mul(8'(x), 8'(y)) == 8'h01) iv8 = 8'(y);
				a = iv8 ^ {iv8[6:0], iv8[7]} ^ {iv8[5:0], iv8[7:6]} ^
					{iv8[4:0], iv8[7:5]} ^ {iv8[3:0], iv8[7:4]} ^ 8'h63;
				fwd[x] = a;
				rev[a] = 8'(x);
			end
			foreach (regs[i]) regs[i] = '0;
			foreach (rkey[i]) rkey[i] = '0;
			chain = '0;
			restart = 1'b1;
		endfunction

		function logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
			logic [7:0] r;
			r = 0;
			for (int i = 0; i < 8; i++) begin
				if (b[i]) r ^= a;
				a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
			end
			return r;
		endfunction

		function void expand_schedule();
			logic [7:0] t [4];
			logic [7:0] tmp, rc;
			rc = 8'h01;
			for (int i = 0; i < 32; i++) rkey[i] = regs[i / 8][63 - 8 * (i % 8) -: 8];
			for (int p = 32; p < 240; p += 4) begin
				for (int i = 0; i < 4; i++) t[i] = rkey[p - 4 + i];
				if (p % 32 == 0) begin
					tmp = t[0]; t[0] = t[1]; t[1] = t[2]; t[2] = t[3]; t[3] = tmp;
					for (int i = 0; i < 4; i++) t[i] = fwd[t[i]];
					t[0] ^= rc;
					rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
				end else if (p % 32 == 16) begin
					for (int i = 0; i < 4; i++) t[i] = fwd[t[i]];
				end
				for (int i = 0; i < 4; i++) rkey[p + i] = rkey[p - 32 + i] ^ t[i];
			end
		endfunction

		function void write_reg(logic [3:0] idx, logic [63:0] val);
			case (idx)
				aes_pkg::REG_KEY0, aes_pkg::REG_KEY1, aes_pkg::REG_KEY2,
				aes_pkg::REG_KEY3: begin
					regs[idx] = val;
					expand_schedule();
					restart = 1'b1;
				end
				aes_pkg::REG_IV_HIGH, aes_pkg::REG_IV_LOW: begin
					regs[idx] = val;
					restart = 1'b1;
				end
				aes_pkg::REG_MODE: regs[idx] = {63'b0, val[0]};
				default: ;
			endcase
		endfunction

		function void add_round(int r);
			for (int i = 0; i < 16; i++) st[i] ^= rkey[16 * r + i];
		endfunction

		function void sub_shift(bit inv);
			logic [7:0] o [16];
			int m;
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++) begin
					m = ((c + r) & 3) * 4 + r;
					if (inv) o[m] = rev[st[c * 4 + r]];
					else o[c * 4 + r] = fwd[st[m]];
				end
			st = o;
		endfunction

		function void mix_cols(bit inv);
			logic [7:0] a [4];
			logic [7:0] m [4];
			if (inv) m = '{8'd14, 8'd11, 8'd13, 8'd9};
			else m = '{8'd2, 8'd3, 8'd1, 8'd1};
			for (int c = 0; c < 4; c++) begin
				for (int k = 0; k < 4; k++) a[k] = st[4 * c + k];
				for (int r = 0; r < 4; r++)
					st[4 * c + r] = gf_mul(a[0], m[(4 - r) & 3]) ^ gf_mul(a[1], m[(5 - r) & 3]) ^
						gf_mul(a[2], m[(6 - r) & 3]) ^ gf_mul(a[3], m[(7 - r) & 3]);
			end
		endfunction

		function logic [127:0] state_vec();
			logic [127:0] v;
			for (int i = 0; i < 16; i++) v[127 - 8 * i -: 8] = st[i];
			return v;
		endfunction

		function void load_state(logic [127:0] v);
			for (int i = 0; i < 16; i++) st[i] = v[127 - 8 * i -: 8];
		endfunction

		function void note_request(logic [63:0] hi, logic [63:0] lo, logic last);
			cbc_block_t e;
			if (restart) begin
				chain = {regs[aes_pkg::REG_IV_HIGH], regs[aes_pkg::REG_IV_LOW]};
				restart = 1'b0;
			end
			if (regs[aes_pkg::REG_MODE][0]) begin
				load_state({hi, lo});
				add_round(14);
				for (int r = 13; r > 0; r--) begin
					sub_shift(1);
					add_round(r);
					mix_cols(1);
				end
				sub_shift(1);
				add_round(0);
				e.blk = state_vec() ^ chain;
				chain = {hi, lo};
			end else begin
				load_state({hi, lo} ^ chain);
				add_round(0);
				for (int r = 1; r < 14; r++) begin
					sub_shift(0);
					mix_cols(0);
					add_round(r);
				end
				sub_shift(0);
				add_round(14);
				e.blk = state_vec();
				chain = e.blk;
			end
			e.last = last;
			expected_blocks.push_back(e);
			if (last) restart = 1'b1;
		endfunction

		function string check_result(logic [63:0] hi, logic [63:0] lo, logic last);
			cbc_block_t e;
			string msg;
			msg = "";
			if (expected_blocks.size() == 0) return "result with no request outstanding";
			e = expected_blocks.pop_front();
			if (hi !== e.blk[127:64])
				msg = {msg, $sformatf(" out_high %h exp %h", hi, e.blk[127:64])};
			if (lo !== e.blk[63:0])
				msg = {msg, $sformatf(" out_low %h exp %h", lo, e.blk[63:0])};
			if (last !== e.last)
				msg = {msg, $sformatf(" out_last %b exp %b", last, e.last)};
			return msg;
		endfunction
	endclass

	logic         clk, arst_n;
	logic         psel, penable, pwrite, pready;
	logic [5:0]   paddr;
	logic [63:0]  pwdata, prdata;
	logic         s_tvalid, s_tready, s_tlast;
	logic [127:0] s_tdata;  // block_low, block_high
	logic         m_tvalid, m_tready, m_tlast;
	logic [127:0] m_tdata;  // out_low, out_high

	cbc_scoreboard sb;
	int  errors;
	int  stuck_cycles;
	int  hold_cycles;
	bit  idle_en;

	aes256_cbc_cipher DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report(string what);
		$display("tb_top: mismatch at %0t:%s", $realtime, what);
		errors++;
	endtask

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			string msg;
			msg = sb.check_result(m_tdata[63:0], m_tdata[127:64], m_tlast);
			if (msg != "") report(msg);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stuck_cycles = 0;
		else stuck_cycles++;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("tb_top: watchdog expired");
			$display("tb_top: done, errors");
			$finish;
		end
	end

	initial begin
		int stall_left;
		stall_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				m_tready = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready = 1'b0;
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 10);
				m_tready = 1'b0;
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	task automatic write_reg(logic [3:0] idx, logic [63:0] val);
		@(negedge clk);
		psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
		paddr = {idx[2:0], 3'b000};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, val);
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
	endtask

	task automatic send_block(logic [63:0] hi, logic [63:0] lo, logic last);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			s_tvalid = 1'b0;
			repeat ($urandom_range(0, 10)) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata = {lo, hi};
		s_tlast = last;
		do @(posedge clk); while (!s_tready);
		sb.note_request(hi, lo, last);
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (sb.expected_blocks.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [63:0] rand_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic send_directed();
		logic [63:0] pat [6];
		pat = '{64'h0, '1, 64'h8000_0000_0000_0000, 64'h1,
			64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa};
		for (int i = 0; i < 6; i++)
			send_block(pat[i], pat[5 - i], i == 2 || i == 5);
		send_block('1, '1, 1'b1);
	endtask

	initial begin
		logic [3:0] keys [4];
		errors = 0;
		stuck_cycles = 0;
		hold_cycles = 0;
		idle_en = 1'b1;
		sb = new();
		arst_n = 1'b0;
		clk = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		s_tvalid = 1'b0; s_tdata = '0; s_tlast = 1'b0;
		keys = '{aes_pkg::REG_KEY0, aes_pkg::REG_KEY1, aes_pkg::REG_KEY2, aes_pkg::REG_KEY3};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin
					foreach (keys[k]) write_reg(keys[k], '0);
					write_reg(aes_pkg::REG_IV_HIGH, '0);
					write_reg(aes_pkg::REG_IV_LOW, '0);
					write_reg(aes_pkg::REG_MODE, 64'd0);
				end
				1: begin
					foreach (keys[k]) write_reg(keys[k], '1);
					write_reg(aes_pkg::REG_IV_HIGH, '1);
					write_reg(aes_pkg::REG_IV_LOW, '1);
					write_reg(aes_pkg::REG_MODE, 64'd1);
				end
				4: begin
					write_reg(aes_pkg::REG_KEY2, rand_word());
					write_reg(REG_SPARE, '1);
					write_reg(aes_pkg::REG_MODE, 64'd0);
				end
				default: begin
					foreach (keys[k]) write_reg(keys[k], rand_word());
					write_reg(aes_pkg::REG_IV_HIGH, rand_word());
					write_reg(aes_pkg::REG_IV_LOW, rand_word());
					write_reg(aes_pkg::REG_MODE, {$urandom, $urandom} & 64'hffff_ffff_ffff_fffe |
						64'(ph % 2));
				end
			endcase
			if (ph == 7) idle_en = 1'b0;
			if (ph < 2) send_directed();
			for (int n = 0; n < 50; n++) begin
				if (ph == 2 && n == 5) hold_cycles = 300;
				if (ph == 3 && n == 25) begin
					drain();
					write_reg(aes_pkg::REG_MODE, 64'd0);
				end
				if (ph == 5 && n == 25) drain();
				send_block(rand_word(), rand_word(), $urandom_range(0, 7) == 0);
			end
			drain();
		end

		if (errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end
endmodule
